FILE: hw/rtl/qsd_pkg.sv
// Shared constants and saturation helpers for the quadrature speed and distance block.
`timescale 1ns / 1ps

package qsd_pkg;

  // Field and register widths
  localparam int COUNT_W  = 16;
  localparam int FUNC_W   = 2;
  localparam int PERIOD_W = 16;
  localparam int PPR_W    = 16;
  localparam int CIRC_W   = 20;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 2;
  localparam int TOTAL_W  = 64;
  localparam int SPEED_W  = 32;
  localparam int TRAVEL_W = 48;

  // Shared unit widths: 16 x 24 multiplier, 44-bit dividend, 32-bit divisor
  localparam int MUL_B_W  = 24;
  localparam int PROD_W   = COUNT_W + MUL_B_W;
  localparam int DC_W     = COUNT_W + CIRC_W;
  localparam int DEN_W    = PERIOD_W + PPR_W;
  localparam int DIV_W    = DC_W + 8;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

  // Constants: 60 s/min * 1000 ms/s * 256
  localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD_MS = 16'd40;
  localparam logic [MUL_B_W-1:0]  RPM_SCALE         = 24'd15360000;

  // Register reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd40;
  localparam logic [PPR_W-1:0]    PPR_RESET    = 16'd1024;
  localparam logic [CIRC_W-1:0]   CIRC_RESET   = 20'd200000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PPR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CIRC   = 2'd2;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_HARD_RESET = 2'd2;

  // Signed 32-bit result from sign and unsigned quotient, clamped
  function automatic logic signed [SPEED_W-1:0] sat32(input logic neg,
                                                      input logic [DIV_W-1:0] q);
    logic signed [SPEED_W-1:0] r;
    if (!neg) begin
      if (q[DIV_W-1:SPEED_W-1] != '0) r = 32'sh7FFF_FFFF;
      else r = q[SPEED_W-1:0];
    end else begin
      if ((q[DIV_W-1:SPEED_W] != '0) || (q[SPEED_W-1] && (q[SPEED_W-2:0] != '0)))
        r = 32'sh8000_0000;
      else r = ~q[SPEED_W-1:0] + 32'd1;
    end
    return r;
  endfunction

  // Add signed step to the travel total, clamped to 48 bits
  function automatic logic signed [TRAVEL_W-1:0] travel_add(
      input logic signed [TRAVEL_W-1:0] acc, input logic neg, input logic [DIV_W-1:0] q);
    logic [DC_W:0]             s;
    logic [TRAVEL_W:0]         sum;
    logic signed [TRAVEL_W-1:0] r;
    s = neg ? (~{1'b0, q[DC_W-1:0]} + (DC_W+1)'(1)) : {1'b0, q[DC_W-1:0]};
    sum = {acc[TRAVEL_W-1], acc} + {{(TRAVEL_W-DC_W){s[DC_W]}}, s};
    if (sum[TRAVEL_W] != sum[TRAVEL_W-1]) begin
      r = sum[TRAVEL_W] ? {1'b1, {(TRAVEL_W-1){1'b0}}} : {1'b0, {(TRAVEL_W-1){1'b1}}};
    end else begin
      r = sum[TRAVEL_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/quadrature_speed_distance.sv
// Quadrature encoder speed and distance block: sequencer, shared multiplier and divider.
`timescale 1ns / 1ps

// Each input beat carries a 16-bit counter sample and a function code. A sample
// (func 0) forms the wrapped signed change from the last sample, adds it to a
// 64-bit pulse total, adds trunc(delta*circ/ppr) to a saturating 48-bit travel
// total, and reports rpm*256 and mm/s*256, truncated toward zero and clamped to
// 32 bits. func 1 clears both totals, func 2 also zeroes the last count, func 3
// changes nothing. A sample passes, after it is accepted, through three steps on one
// 16x24 multiplier (S_MDEN, S_MDC, S_MRPM), three 44-bit divisions on one shared
// restoring divider (one quotient bit per cycle, each followed by a store state),
// and a load into the result register; no next beat is accepted until the block is
// back in idle. A clear, hard reset or unused code goes from idle straight to the
// load state. The load waits while the result register still holds an untaken
// beat. in_stall is high while an item is in work; the output register lets the
// next item enter while a result waits to be taken.
module quadrature_speed_distance
  import qsd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [FUNC_W-1:0]           func,
  input  logic [COUNT_W-1:0]          count_sample,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [COUNT_W-1:0]   pulse_delta,
  output logic signed [TOTAL_W-1:0]   pulse_total,
  output logic signed [SPEED_W-1:0]   speed_rpm_q8,
  output logic signed [SPEED_W-1:0]   speed_mmps_q8,
  output logic signed [TRAVEL_W-1:0]  travel_um
);

  typedef enum logic [2:0] {
    S_IDLE, S_MDEN, S_MDC, S_MRPM, S_DIV, S_POST, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_RPM, PH_MMPS, PH_STEP
  } phase_t;

  state_t state;
  phase_t phase;

  // configuration registers
  logic [PERIOD_W-1:0] period_ms;
  logic [PPR_W-1:0]    pulses_per_rev;
  logic [CIRC_W-1:0]   wheel_circumference_um;

  // block state
  logic [COUNT_W-1:0]         prev_count;
  logic [TOTAL_W-1:0]         pulse_accum;
  logic signed [TRAVEL_W-1:0] travel_accum;

  // per-item working registers
  logic [COUNT_W-1:0]         diff;
  logic [COUNT_W-1:0]         mag;
  logic                       neg;
  logic [DEN_W-1:0]           den;
  logic [DC_W-1:0]            dc;
  logic signed [SPEED_W-1:0]  rpm_r;
  logic signed [SPEED_W-1:0]  mmps_r;

  // divider registers
  logic [DIV_W-1:0]     dq;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     divisor;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic                 in_fire;
  logic                 out_load;
  logic [COUNT_W-1:0]   diff_next;
  logic [PERIOD_W-1:0]  per_eff;
  logic [PPR_W-1:0]     ppr_eff;
  logic [COUNT_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    prod;
  logic [DEN_W:0]       rem_sh;
  logic                 q_bit;
  logic [DEN_W-1:0]     rem_next;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  assign diff_next = count_sample - prev_count;
  assign per_eff   = (period_ms == '0) ? DEFAULT_PERIOD_MS : period_ms;
  assign ppr_eff   = (pulses_per_rev == '0) ? PPR_W'(1) : pulses_per_rev;

  // shared multiplier operand select
  always_comb begin
    mul_a = mag;
    mul_b = RPM_SCALE;
    case (state)
      S_MDEN: begin
        mul_a = per_eff;
        mul_b = {{(MUL_B_W-PPR_W){1'b0}}, ppr_eff};
      end
      S_MDC: mul_b = {{(MUL_B_W-CIRC_W){1'b0}}, wheel_circumference_um};
      default: mul_b = RPM_SCALE;
    endcase
  end

  assign prod = mul_a * mul_b;

  // one restoring division step
  assign rem_sh   = {rem, dq[DIV_W-1]};
  assign q_bit    = (rem_sh >= {1'b0, divisor});
  assign rem_next = q_bit ? DEN_W'(rem_sh - {1'b0, divisor}) : rem_sh[DEN_W-1:0];

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state                  <= S_IDLE;
      phase                  <= PH_RPM;
      out_valid              <= 1'b0;
      period_ms              <= PERIOD_RESET;
      pulses_per_rev         <= PPR_RESET;
      wheel_circumference_um <= CIRC_RESET;
      prev_count             <= '0;
      pulse_accum            <= '0;
      travel_accum           <= '0;
      div_cnt                <= '0;
    end else begin
      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PERIOD: period_ms              <= cfg_data[PERIOD_W-1:0];
          REG_PPR:    pulses_per_rev         <= cfg_data[PPR_W-1:0];
          REG_CIRC:   wheel_circumference_um <= cfg_data[CIRC_W-1:0];
          default: ;
        endcase
      end

      // result register loaded or output beat taken
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            // codes other than a sample report zero change and zero speed
            diff   <= (func == FUNC_SAMPLE) ? diff_next : '0;
            neg    <= diff_next[COUNT_W-1];
            mag    <= diff_next[COUNT_W-1] ? (~diff_next + COUNT_W'(1)) : diff_next;
            rpm_r  <= '0;
            mmps_r <= '0;
            state  <= (func == FUNC_SAMPLE) ? S_MDEN : S_OUT;
            case (func)
              FUNC_SAMPLE: begin
                prev_count  <= count_sample;
                pulse_accum <= pulse_accum
                             + {{(TOTAL_W-COUNT_W){diff_next[COUNT_W-1]}}, diff_next};
              end
              FUNC_CLEAR: begin
                pulse_accum  <= '0;
                travel_accum <= '0;
              end
              FUNC_HARD_RESET: begin
                pulse_accum  <= '0;
                travel_accum <= '0;
                prev_count   <= '0;
              end
              default: ;
            endcase
          end
        end

        S_MDEN: begin
          den   <= prod[DEN_W-1:0];
          state <= S_MDC;
        end

        S_MDC: begin
          dc    <= prod[DC_W-1:0];
          state <= S_MRPM;
        end

        // start rpm division: |diff|*scale / (period*ppr)
        S_MRPM: begin
          dq      <= {{(DIV_W-PROD_W){1'b0}}, prod};
          rem     <= '0;
          divisor <= den;
          div_cnt <= '0;
          phase   <= PH_RPM;
          state   <= S_DIV;
        end

        S_DIV: begin
          dq      <= {dq[DIV_W-2:0], q_bit};
          rem     <= rem_next;
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_LAST) state <= S_POST;
        end

        // store quotient, then start the next division or, after the last, go to output
        S_POST: begin
          rem     <= '0;
          div_cnt <= '0;
          case (phase)
            PH_RPM: begin
              rpm_r <= sat32(neg, dq);
              dq    <= {dc, 8'd0};
              phase <= PH_MMPS;
              state <= S_DIV;
            end
            PH_MMPS: begin
              mmps_r  <= sat32(neg, dq);
              dq      <= {8'd0, dc};
              divisor <= {{(DEN_W-PPR_W){1'b0}}, ppr_eff};
              phase   <= PH_STEP;
              state   <= S_DIV;
            end
            default: begin
              travel_accum <= travel_add(travel_accum, neg, dq);
              state        <= S_OUT;
            end
          endcase
        end

        // load the result register once it is free
        S_OUT: begin
          if (out_load) begin
            pulse_delta   <= diff;
            pulse_total   <= pulse_accum;
            speed_rpm_q8  <= rpm_r;
            speed_mmps_q8 <= mmps_r;
            travel_um     <= travel_accum;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
